// File: rtl/mecanum_odometry_frame_receiver_macros.svh
`ifndef MECANUM_ODOMETRY_FRAME_RECEIVER_MACROS_SVH
`define MECANUM_ODOMETRY_FRAME_RECEIVER_MACROS_SVH

// Checks on clk, quiet while rst is high.
`define MOFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks on clk, reset cycles included.
`define MOFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mofr_pkg.sv
`timescale 1ns / 1ps
package mofr_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h7B;
  localparam logic [7:0] TAIL_BYTE = 8'h7D;
  localparam int FRAME_LEN = 11;
  localparam int COUNT_BITS = $clog2(FRAME_LEN);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS            = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERSE_LEVER_ARM = 2'd1;
  localparam logic [15:0] RADIUS_RESET = 16'd1966;
  localparam logic [23:0] LEVER_RESET  = 24'd378822;

  localparam logic [31:0] CORDIC_GAIN    = 32'h9B74EDA8;
  localparam logic [31:0] BAM_PER_RAD_US = 32'd44798134;
  localparam int CORDIC_STEPS = 16;

  // rounding biases and pre-shifts ahead of the constant dividers
  localparam logic [63:0] VEL_BIAS = 64'd2000;
  localparam logic [63:0] YAW_BIAS = 64'd131072000;
  localparam logic [63:0] POS_BIAS = 64'd500000;
  localparam logic [63:0] ROUND_Q32 = 64'h0000_0000_8000_0000;
  localparam int YAW_SHIFT = 16;
  localparam int POS_SHIFT = 6;

  localparam int DIVISOR_BITS = 14;
  typedef enum logic {DIV_BY_4000, DIV_BY_15625} div_sel_t;

  // reciprocals for one 30-bit partial dividend: ceil(2^42/4000), ceil(2^44/15625)
  localparam logic [31:0] RECIP_4000  = 32'd1099511628;
  localparam logic [31:0] RECIP_15625 = 32'd1125899907;

  function automatic logic [DIVISOR_BITS-1:0] div_value(input div_sel_t s);
    logic [DIVISOR_BITS-1:0] v;
    unique case (s)
      DIV_BY_4000:  v = 14'd4000;
      DIV_BY_15625: v = 14'd15625;
      default:      v = 14'd4000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] div_recip(input div_sel_t s);
    logic [31:0] v;
    unique case (s)
      DIV_BY_4000:  v = RECIP_4000;
      DIV_BY_15625: v = RECIP_15625;
      default:      v = RECIP_4000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] atan_bam(input logic [3:0] i);
    logic [31:0] v;
    unique case (i)
      4'd0:  v = 32'h20000000;
      4'd1:  v = 32'h12E4051E;
      4'd2:  v = 32'h09FB385B;
      4'd3:  v = 32'h051111D4;
      4'd4:  v = 32'h028B0D43;
      4'd5:  v = 32'h0145D7E1;
      4'd6:  v = 32'h00A2F61E;
      4'd7:  v = 32'h00517C55;
      4'd8:  v = 32'h0028BE53;
      4'd9:  v = 32'h00145F2F;
      4'd10: v = 32'h000A2F98;
      4'd11: v = 32'h000517CC;
      4'd12: v = 32'h00028BE6;
      4'd13: v = 32'h000145F3;
      4'd14: v = 32'h0000A2F9;
      4'd15: v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic               bad;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
    logic signed [15:0] w4;
  } frame_t;

endpackage

// File: rtl/mofr_if.sv
`timescale 1ns / 1ps
interface mofr_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface mofr_result_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  modport source (output valid, status, vel_x, vel_y, yaw_rate, pos_x, pos_y, heading,
                  input ready);
  modport sink   (input valid, status, vel_x, vel_y, yaw_rate, pos_x, pos_y, heading,
                  output ready);
endinterface

// File: rtl/mofr_front.sv
`timescale 1ns / 1ps
module mofr_front
  import mofr_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  mofr_item_if.sink                  items,
  output frame_t                     frame,
  output logic [TICK_COUNT_BITS-1:0] frame_ticks,
  output logic                       push,
  input  logic                       full
);

  logic [7:0]                 frame_store [FRAME_LEN];
  logic [COUNT_BITS-1:0]      byte_count;
  logic                       in_frame;
  logic [TICK_COUNT_BITS-1:0] elapsed_ticks;

  logic       accept, is_tick, take_byte, last;
  logic [7:0] chk;

  assign items.ready = !full;
  assign accept    = items.valid && items.ready;
  assign is_tick   = items.command == CMD_TICK;
  assign take_byte = accept && !is_tick && (in_frame || items.data_byte == HDR_BYTE);
  assign last      = byte_count == COUNT_BITS'(FRAME_LEN - 1);
  assign push      = take_byte && last && items.data_byte == TAIL_BYTE;

  always_comb begin
    chk = 8'h00;
    for (int i = 0; i < 9; i++) begin
      chk = chk ^ frame_store[i];
    end
  end

  assign frame.bad = chk != frame_store[9];
  assign frame.w1  = {frame_store[1], frame_store[2]};
  assign frame.w2  = {frame_store[3], frame_store[4]};
  assign frame.w3  = {frame_store[5], frame_store[6]};
  assign frame.w4  = {frame_store[7], frame_store[8]};
  assign frame_ticks = elapsed_ticks;

  always_ff @(posedge clk) begin
    if (take_byte) begin
      frame_store[byte_count] <= items.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      in_frame      <= 1'b0;
      elapsed_ticks <= '0;
    end else begin
      if (accept && is_tick && elapsed_ticks != '1) begin
        elapsed_ticks <= elapsed_ticks + 1'b1;
      end
      if (take_byte) begin
        if (last) begin
          byte_count <= '0;
          in_frame   <= 1'b0;
        end else begin
          byte_count <= byte_count + 1'b1;
          in_frame   <= 1'b1;
        end
      end
      // ticks restart only once a frame is known good
      if (push && !frame.bad) begin
        elapsed_ticks <= '0;
      end
    end
  end

endmodule

// File: rtl/mofr_fifo.sv
`timescale 1ns / 1ps
module mofr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  `include "mecanum_odometry_frame_receiver_macros.svh"

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `MOFR_ASSERT(a_no_push_full, push |-> !full, "queue written while full")
  `MOFR_ASSERT(a_no_pop_empty, pop |-> !empty, "queue read while empty")

endmodule

// File: rtl/mofr_mul.sv
`timescale 1ns / 1ps
module mofr_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  // 64 x 32 product modulo 2^64, as two 32 x 32 partials
  typedef enum logic [1:0] {M_IDLE, M_HI, M_SUM} mstate_t;

  mstate_t     state;
  logic [63:0] part;
  logic [31:0] a_hi, b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            part  <= a[31:0] * b;
            a_hi  <= a[63:32];
            b_r   <= b;
            state <= M_HI;
          end
        end
        M_HI: begin
          prod  <= part;
          part  <= a_hi * b_r;
          state <= M_SUM;
        end
        M_SUM: begin
          prod  <= prod + {part[31:0], 32'h0};
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mofr_div.sv
`timescale 1ns / 1ps
module mofr_div
  import mofr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  div_sel_t    sel,
  output logic        done,
  output logic [63:0] quotient
);

  // division by a small constant, four 16-bit digits from the top; each digit
  // quotient comes from a registered reciprocal multiply, the remainder with it
  localparam int PART_BITS = DIVISOR_BITS + 16;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_SUB} dstate_t;

  dstate_t                 state;
  logic [63:0]             work;
  logic [DIVISOR_BITS-1:0] rem;
  logic [1:0]              digit;
  div_sel_t                sel_r;
  logic [61:0]             prod;

  logic [PART_BITS-1:0] part, qd_d, rem_full;
  logic [15:0]          qd;

  assign part     = {rem, work[63:48]};
  assign qd       = (sel_r == DIV_BY_4000) ? prod[57:42] : prod[59:44];
  assign qd_d     = PART_BITS'(qd) * PART_BITS'(div_value(sel_r));
  assign rem_full = part - qd_d;
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      digit <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            work  <= dividend;
            rem   <= '0;
            sel_r <= sel;
            digit <= '0;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          prod  <= {32'd0, part} * {30'd0, div_recip(sel_r)};
          state <= D_SUB;
        end
        D_SUB: begin
          work  <= {work[47:0], qd};
          rem   <= rem_full[DIVISOR_BITS-1:0];
          digit <= digit + 1'b1;
          if (digit == 2'd3) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            state <= D_MUL;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mofr_back.sv
`timescale 1ns / 1ps
module mofr_back
  import mofr_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       job_valid,
  input  frame_t                     job,
  input  logic [TICK_COUNT_BITS-1:0] job_ticks,
  output logic                       pop,
  mofr_result_if.source              results
);

  `include "mecanum_odometry_frame_receiver_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE, ST_VX_MUL, ST_VX_DIV, ST_VY_MUL, ST_VY_DIV,
    ST_VZ_MUL1, ST_VZ_MUL2, ST_VZ_DIV, ST_ROT_FOLD, ST_ROT_ITER,
    ST_GX_MUL, ST_GY_MUL, ST_PX_MUL, ST_PX_DIV, ST_PY_MUL, ST_PY_DIV,
    ST_HD_MUL1, ST_HD_MUL2, ST_OUT
  } bstate_t;

  logic [15:0] radius;
  logic [23:0] inverse_lever_arm;

  bstate_t                    state;
  logic                       issued;
  logic                       bad;
  logic signed [17:0]         s_sum, d_sum, y_sum;
  logic [TICK_COUNT_BITS-1:0] ticks;
  logic [63:0]                t0;
  logic signed [31:0]         vx, vy, vz, cx, cy, rx, ry;
  logic signed [33:0]         z;
  logic [3:0]                 step;
  logic signed [31:0]         position_x, position_y;
  logic [31:0]                heading_angle;

  logic               res_valid, res_status;
  logic signed [31:0] res_vx, res_vy, res_vz, res_px, res_py;
  logic [31:0]        res_hd;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_prod, div_dividend, div_q, mul_rnd;
  logic [31:0] mul_b, ang_f;
  div_sel_t    div_sel;
  logic        is_mul, is_div;

  logic signed [17:0] w1e, w2e, w3e, w4e;
  logic signed [36:0] dx_mag;

  function automatic logic [17:0] mag18(input logic signed [17:0] v);
    return v[17] ? 18'(-v) : 18'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [36:0] d);
    logic signed [37:0] s;
    logic signed [31:0] r;
    s = 38'(p) + 38'(d);
    if (s > 38'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (s < -38'sd2147483648) r = 32'sh80000000;
    else                           r = s[31:0];
    return r;
  endfunction

  assign w1e = 18'(job.w1);
  assign w2e = 18'(job.w2);
  assign w3e = 18'(job.w3);
  assign w4e = 18'(job.w4);

  assign pop = state == ST_IDLE && job_valid;

  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_VX_MUL:  begin mul_a = 64'(mag18(s_sum)); mul_b = 32'(radius); end
      ST_VY_MUL:  begin mul_a = 64'(mag18(d_sum)); mul_b = 32'(radius); end
      ST_VZ_MUL1: begin mul_a = 64'(mag18(y_sum)); mul_b = 32'(radius); end
      ST_VZ_MUL2: begin mul_a = t0;                mul_b = 32'(inverse_lever_arm); end
      ST_GX_MUL:  begin mul_a = 64'(mag32(cx));    mul_b = CORDIC_GAIN; end
      ST_GY_MUL:  begin mul_a = 64'(mag32(cy));    mul_b = CORDIC_GAIN; end
      ST_PX_MUL:  begin mul_a = 64'(mag32(rx));    mul_b = 32'(ticks); end
      ST_PY_MUL:  begin mul_a = 64'(mag32(ry));    mul_b = 32'(ticks); end
      ST_HD_MUL1: begin mul_a = 64'(mag32(vz));    mul_b = 32'(ticks); end
      ST_HD_MUL2: begin mul_a = t0;                mul_b = BAM_PER_RAD_US; end
      default:    is_mul = 1'b0;
    endcase
  end

  always_comb begin
    is_div       = 1'b1;
    div_dividend = '0;
    div_sel      = DIV_BY_4000;
    case (state)
      ST_VX_DIV, ST_VY_DIV: div_dividend = t0 + VEL_BIAS;
      ST_VZ_DIV:            div_dividend = (t0 + YAW_BIAS) >> YAW_SHIFT;
      ST_PX_DIV, ST_PY_DIV: begin
        div_dividend = (t0 + POS_BIAS) >> POS_SHIFT;
        div_sel      = DIV_BY_15625;
      end
      default: is_div = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !issued;
  assign div_start = is_div && !issued;
  assign mul_rnd   = mul_prod + ROUND_Q32;
  assign dx_mag    = 37'(div_q[35:0]);
  assign ang_f     = (heading_angle[31:30] == 2'b01 || heading_angle[31:30] == 2'b10) ?
                     heading_angle + 32'h8000_0000 : heading_angle;

  mofr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mofr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .sel      (div_sel),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius            <= RADIUS_RESET;
      inverse_lever_arm <= LEVER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:            radius            <= cfg_data[15:0];
        CFG_INVERSE_LEVER_ARM: inverse_lever_arm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      issued        <= 1'b0;
      res_valid     <= 1'b0;
      position_x    <= '0;
      position_y    <= '0;
      heading_angle <= '0;
    end else begin
      // ST_OUT reloads the result register itself
      if (results.valid && results.ready && state != ST_OUT) res_valid <= 1'b0;
      if ((is_mul || is_div) && !issued) issued <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            bad   <= job.bad;
            s_sum <= w1e + w2e + w3e + w4e;
            d_sum <= w2e - w1e + w4e - w3e;
            y_sum <= w3e + w4e - w1e - w2e;
            ticks <= job_ticks;
            state <= job.bad ? ST_OUT : ST_VX_MUL;
          end
        end
        ST_VX_MUL: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_VX_DIV;
        end
        ST_VX_DIV: if (issued && div_done) begin
          vx <= s_sum[17] ? -div_q[31:0] : div_q[31:0];
          issued <= 1'b0; state <= ST_VY_MUL;
        end
        ST_VY_MUL: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_VY_DIV;
        end
        ST_VY_DIV: if (issued && div_done) begin
          vy <= d_sum[17] ? -div_q[31:0] : div_q[31:0];
          issued <= 1'b0; state <= ST_VZ_MUL1;
        end
        ST_VZ_MUL1: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_VZ_MUL2;
        end
        ST_VZ_MUL2: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_VZ_DIV;
        end
        ST_VZ_DIV: if (issued && div_done) begin
          vz <= y_sum[17] ? -div_q[31:0] : div_q[31:0];
          issued <= 1'b0; state <= ST_ROT_FOLD;
        end
        ST_ROT_FOLD: begin
          // fold the back half-plane by a half turn
          if (ang_f != heading_angle) begin
            cx <= -vx;
            cy <= -vy;
          end else begin
            cx <= vx;
            cy <= vy;
          end
          z     <= 34'(signed'(ang_f));
          step  <= '0;
          state <= ST_ROT_ITER;
        end
        ST_ROT_ITER: begin
          if (!z[33]) begin
            cx <= cx - (cy >>> step);
            cy <= cy + (cx >>> step);
            z  <= z - 34'(atan_bam(step));
          end else begin
            cx <= cx + (cy >>> step);
            cy <= cy - (cx >>> step);
            z  <= z + 34'(atan_bam(step));
          end
          step <= step + 1'b1;
          if (step == 4'(CORDIC_STEPS - 1)) state <= ST_GX_MUL;
        end
        ST_GX_MUL: if (issued && mul_done) begin
          rx <= cx[31] ? -mul_rnd[63:32] : mul_rnd[63:32];
          issued <= 1'b0; state <= ST_GY_MUL;
        end
        ST_GY_MUL: if (issued && mul_done) begin
          ry <= cy[31] ? -mul_rnd[63:32] : mul_rnd[63:32];
          issued <= 1'b0; state <= ST_PX_MUL;
        end
        ST_PX_MUL: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_PX_DIV;
        end
        ST_PX_DIV: if (issued && div_done) begin
          position_x <= sat_add(position_x, rx[31] ? -dx_mag : dx_mag);
          issued <= 1'b0; state <= ST_PY_MUL;
        end
        ST_PY_MUL: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_PY_DIV;
        end
        ST_PY_DIV: if (issued && div_done) begin
          position_y <= sat_add(position_y, ry[31] ? -dx_mag : dx_mag);
          issued <= 1'b0; state <= ST_HD_MUL1;
        end
        ST_HD_MUL1: if (issued && mul_done) begin
          t0 <= mul_prod; issued <= 1'b0; state <= ST_HD_MUL2;
        end
        ST_HD_MUL2: if (issued && mul_done) begin
          heading_angle <= heading_angle +
                           (vz[31] ? -mul_rnd[63:32] : mul_rnd[63:32]);
          issued <= 1'b0; state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid || results.ready) begin
            res_valid  <= 1'b1;
            res_status <= bad;
            res_vx     <= bad ? '0 : vx;
            res_vy     <= bad ? '0 : vy;
            res_vz     <= bad ? '0 : vz;
            res_px     <= bad ? '0 : position_x;
            res_py     <= bad ? '0 : position_y;
            res_hd     <= bad ? '0 : heading_angle;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid    = res_valid;
  assign results.status   = res_status;
  assign results.vel_x    = res_vx;
  assign results.vel_y    = res_vy;
  assign results.yaw_rate = res_vz;
  assign results.pos_x    = res_px;
  assign results.pos_y    = res_py;
  assign results.heading  = res_hd;

  `MOFR_ASSERT(a_mul_done_issued, mul_done |-> issued && is_mul, "stray multiply done")
  `MOFR_ASSERT(a_div_done_issued, div_done |-> issued && is_div, "stray divide done")
  `MOFR_ASSERT_ALWAYS(a_idle_clear, state == ST_IDLE |-> !issued, "op flag left set in idle")

endmodule

// File: rtl/mecanum_odometry_frame_receiver.sv
`timescale 1ns / 1ps
// Throughput: one byte or tick transaction a cycle while the frame queue has room.
// The back end works a good frame through ten multiplies, five reciprocal
// constant divides, 16 CORDIC steps and control states; a bad frame goes
// straight to the result. Reset (rst, synchronous, active high) clears hunting,
// ticks, pose and queue, and restores both configuration registers.
// No clearing pass.
module mecanum_odometry_frame_receiver
  import mofr_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  mofr_item_if.sink                 items,
  mofr_result_if.source             results
);

  // Front: header hunt, byte store, checksum and tick count. Each tailed
  // frame becomes one queue entry with its tick snapshot.
  // Back: kinematics, heading rotation and pose integration, one frame at a
  // time, through a shared multiplier and a shared constant divider.

  localparam int JOB_BITS = $bits(frame_t) + TICK_COUNT_BITS;

  frame_t                     front_frame, back_frame;
  logic [TICK_COUNT_BITS-1:0] front_ticks, back_ticks;
  logic                       push, pop, full, empty;
  logic [JOB_BITS-1:0]        q_rdata;

  mofr_front #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .frame       (front_frame),
    .frame_ticks (front_ticks),
    .push        (push),
    .full        (full)
  );

  // two-entry queue so the front keeps taking bytes while the back works
  mofr_fifo #(.WIDTH(JOB_BITS)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({front_frame, front_ticks}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (full),
    .empty (empty)
  );

  assign back_frame = q_rdata[JOB_BITS-1:TICK_COUNT_BITS];
  assign back_ticks = q_rdata[TICK_COUNT_BITS-1:0];

  mofr_back #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (!empty),
    .job       (back_frame),
    .job_ticks (back_ticks),
    .pop       (pop),
    .results   (results)
  );

endmodule
